// ===== design/cfnm_pkg.sv =====
// ----------------------------------------------------------------------------
// cfnm_pkg: shared definitions for the cron field next-match block
// Value width, register indexes, the configuration group and the word that
// travels down the chain of search cells.
// ----------------------------------------------------------------------------
package cfnm_pkg;

  // Width of a field value and the number of values it can take.
  localparam int VALUE_BITS = 6;
  localparam int NVALS      = 1 << VALUE_BITS;
  localparam int HALF       = NVALS / 2;

  // Fixed widths of the ports and configuration registers.
  localparam int FIELD_W   = 6;
  localparam int CFG_W     = 6;
  localparam int MASK_W    = 64;
  localparam int REG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ALLOWED_MASK = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_START  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_END    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_PERIOD  = 2'd3;

  // Configuration seen by the datapath; period already has zero mapped to one.
  typedef struct packed {
    logic [MASK_W-1:0] allowed_mask;
    logic [CFG_W-1:0]  range_start;
    logic [CFG_W-1:0]  range_end;
    logic [CFG_W-1:0]  period;
  } cfnm_cfg_t;

  // Word handed from cell to cell.
  typedef struct packed {
    logic                  list_mode;  // mask has any set bit
    logic                  list_wrap;  // no listed value at or above the probe
    logic                  below;      // probe below range start
    logic [VALUE_BITS-1:0] probe;
    logic [NVALS-1:0]      vec;        // search vector, bits stretched per level
    logic [VALUE_BITS-1:0] idx;        // lowest set bit index, built MSB first
    logic [VALUE_BITS-1:0] dvd;        // dividend bits still to shift in
    logic [CFG_W-1:0]      rem;        // partial remainder of the range offset
  } cfnm_word_t;

endpackage

// ===== design/cron_field_next_match_top.sv =====
// ----------------------------------------------------------------------------
// cron_field_next_match_top: next allowed value of one cron field
// Usage:
//   The input channel (in_valid/in_ready) takes one probe value per word.
//   The output channel (out_valid/out_ready) returns one word per probe: the
//   first allowed value at or after the probe and a wrap flag.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   allowed-value mask, range start, range end and step period by index.
//   The user must change configuration only while no probe is in flight;
//   the block itself does not enforce this.
// Timing:
//   A probe passes an entry stage, VALUE_BITS search cells and an output
//   register; the entry stage loads at the accepting edge. One probe is
//   accepted every cycle while the output is not stalled.
//   Each cell of the chain settles one index bit and one remainder bit.
// Reset and stall:
//   Reset empties the chain and loads the register defaults (empty mask,
//   range 0 to 63, period 1). While out_valid is high and out_ready low the
//   whole chain holds and in_ready is low; words in flight are kept.
// ----------------------------------------------------------------------------
module cron_field_next_match_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cfnm_pkg::FIELD_W-1:0]     in_probe_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cfnm_pkg::FIELD_W-1:0]     out_match_value,
  output logic                             out_wrapped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfnm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [cfnm_pkg::MASK_W-1:0]      cfg_data
);
  import cfnm_pkg::*;

  logic [MASK_W-1:0]  allowed_mask_r;
  logic [CFG_W-1:0]   range_start_r;
  logic [CFG_W-1:0]   range_end_r;
  logic [CFG_W-1:0]   step_period_r;
  cfnm_cfg_t          cfg;
  logic               en;
  logic [VALUE_BITS:0] stage_vld;
  cfnm_word_t         stage_word [0:VALUE_BITS];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_mask_r <= '0;
      range_start_r  <= '0;
      range_end_r    <= '1;
      step_period_r  <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALLOWED_MASK: allowed_mask_r <= cfg_data;
        REG_RANGE_START:  range_start_r  <= cfg_data[CFG_W-1:0];
        REG_RANGE_END:    range_end_r    <= cfg_data[CFG_W-1:0];
        REG_STEP_PERIOD:  step_period_r  <= cfg_data[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero period steps like a period of one.
  always_comb begin
    cfg.allowed_mask = allowed_mask_r;
    cfg.range_start  = range_start_r;
    cfg.range_end    = range_end_r;
    cfg.period       = (step_period_r == '0) ? CFG_W'(1) : step_period_r;
  end

  // The whole chain advances unless a finished word is waiting.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cfnm_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_probe (in_probe_value),
    .cfg      (cfg),
    .out_vld  (stage_vld[0]),
    .out_word (stage_word[0])
  );

  // One cell per index bit.
  for (genvar k = 0; k < VALUE_BITS; k++) begin : g_cell
    cfnm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .period   (cfg.period),
      .in_vld   (stage_vld[k]),
      .in_word  (stage_word[k]),
      .out_vld  (stage_vld[k+1]),
      .out_word (stage_word[k+1])
    );
  end

  cfnm_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .cfg             (cfg),
    .in_vld          (stage_vld[VALUE_BITS]),
    .in_word         (stage_word[VALUE_BITS]),
    .out_valid       (out_valid),
    .out_match_value (out_match_value),
    .out_wrapped     (out_wrapped)
  );

  // Reset empties every stage of the chain and the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (stage_vld == '0) && !out_valid)
    else $error("chain not empty after reset");

  // An accepted word enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> stage_vld[0])
    else $error("accepted word did not enter the chain");

  // When the chain moves, every valid bit moves one stage along.
  a_chain_shift: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (stage_vld[VALUE_BITS:1] == $past(stage_vld[VALUE_BITS-1:0])) &&
           (out_valid == $past(stage_vld[VALUE_BITS])))
    else $error("chain valid bits did not advance");

  // When the chain is stalled, no stage gains or loses a word.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(stage_vld) && out_valid)
    else $error("chain changed while stalled");

endmodule

// ===== design/cfnm_prep.sv =====
// ----------------------------------------------------------------------------
// cfnm_prep: entry stage of the search chain
// Masks the probe to the value range, clears mask bits below the probe, picks
// the wrap vector and forms the range offset for the remainder cells.
// ----------------------------------------------------------------------------
module cfnm_prep (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [cfnm_pkg::FIELD_W-1:0]    in_probe,
  input  cfnm_pkg::cfnm_cfg_t             cfg,
  output logic                            out_vld,
  output cfnm_pkg::cfnm_word_t            out_word
);
  import cfnm_pkg::*;

  logic [VALUE_BITS-1:0] probe;
  logic [VALUE_BITS-1:0] start;
  logic [NVALS-1:0]      mask;
  logic [NVALS-1:0]      above;
  logic                  has_above;
  cfnm_word_t            word_nxt;
  cfnm_word_t            word_r;
  logic                  vld_r;

  // Listed values at or above the probe, falling back to the whole list.
  always_comb begin
    probe     = in_probe[VALUE_BITS-1:0];
    start     = cfg.range_start[VALUE_BITS-1:0];
    mask      = cfg.allowed_mask[NVALS-1:0];
    above     = mask & ({NVALS{1'b1}} << probe);
    has_above = |above;

    word_nxt           = '0;
    word_nxt.list_mode = |mask;
    word_nxt.list_wrap = ~has_above;
    word_nxt.below     = probe < start;
    word_nxt.probe     = probe;
    word_nxt.vec       = has_above ? above : mask;
    word_nxt.dvd       = probe - start;
    word_nxt.rem       = '0;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== design/cfnm_cell.sv =====
// ----------------------------------------------------------------------------
// cfnm_cell: one level of the search chain
// Settles one index bit of the lowest set bit by testing the low half of the
// search vector, and performs one restoring step of the range remainder.
// ----------------------------------------------------------------------------
module cfnm_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [cfnm_pkg::CFG_W-1:0]      period,
  input  logic                            in_vld,
  input  cfnm_pkg::cfnm_word_t            in_word,
  output logic                            out_vld,
  output cfnm_pkg::cfnm_word_t            out_word
);
  import cfnm_pkg::*;

  logic                 lo_zero;
  logic [HALF-1:0]      half;
  logic [NVALS-1:0]     stretched;
  logic [CFG_W:0]       rsh;
  cfnm_word_t           word_nxt;
  cfnm_word_t           word_r;
  logic                 vld_r;

  always_comb begin
    // Keep the half holding the lowest set bit, then double every bit so the
    // next level again tests the low half of a full-width vector.
    lo_zero = ~|in_word.vec[HALF-1:0];
    half    = lo_zero ? in_word.vec[NVALS-1:HALF] : in_word.vec[HALF-1:0];
    for (int i = 0; i < HALF; i++) begin
      stretched[2*i]   = half[i];
      stretched[2*i+1] = half[i];
    end

    // One restoring division step on the next dividend bit.
    rsh = {in_word.rem, in_word.dvd[VALUE_BITS-1]};

    word_nxt     = in_word;
    word_nxt.vec = stretched;
    word_nxt.idx = {in_word.idx[VALUE_BITS-2:0], lo_zero};
    word_nxt.dvd = in_word.dvd << 1;
    if (rsh >= {1'b0, period}) begin
      word_nxt.rem = CFG_W'(rsh - {1'b0, period});
    end else begin
      word_nxt.rem = rsh[CFG_W-1:0];
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule

// ===== design/cfnm_finish.sv =====
// ----------------------------------------------------------------------------
// cfnm_finish: result stage of the search chain
// Rounds the probe up to the next step in range mode, checks it against the
// range end, selects the list or range answer and holds it for the receiver.
// ----------------------------------------------------------------------------
module cfnm_finish (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  cfnm_pkg::cfnm_cfg_t             cfg,
  input  logic                            in_vld,
  input  cfnm_pkg::cfnm_word_t            in_word,
  output logic                            out_valid,
  output logic [cfnm_pkg::FIELD_W-1:0]    out_match_value,
  output logic                            out_wrapped
);
  import cfnm_pkg::*;

  logic [CFG_W:0]       gap;
  logic [CFG_W:0]       next_val;
  logic [CFG_W:0]       end_ext;
  logic [FIELD_W-1:0]   start_val;
  logic [FIELD_W-1:0]   match_nxt;
  logic                 wrap_nxt;
  logic                 valid_r;
  logic [FIELD_W-1:0]   match_r;
  logic                 wrap_r;

  always_comb begin
    // Distance to the next step is period minus remainder, none on a step.
    gap       = {1'b0, cfg.period} - {1'b0, in_word.rem};
    next_val  = (in_word.rem == '0) ? (CFG_W+1)'(in_word.probe)
                                    : (CFG_W+1)'(in_word.probe) + gap;
    end_ext   = (CFG_W+1)'(cfg.range_end[VALUE_BITS-1:0]);
    start_val = FIELD_W'(cfg.range_start[VALUE_BITS-1:0]);

    if (in_word.list_mode) begin
      match_nxt = FIELD_W'(in_word.idx);
      wrap_nxt  = in_word.list_wrap;
    end else if (in_word.below) begin
      match_nxt = start_val;
      wrap_nxt  = 1'b0;
    end else if (next_val > end_ext) begin
      match_nxt = start_val;
      wrap_nxt  = 1'b1;
    end else begin
      match_nxt = next_val[FIELD_W-1:0];
      wrap_nxt  = 1'b0;
    end
  end

  // Output register, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      match_r <= match_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_match_value = match_r;
  assign out_wrapped     = wrap_r;

endmodule
